FILE: src/baq_pkg.sv
// baq_pkg: shared types, constants and helpers for the battery alert qualifier
// no dependencies; used by baq_cfg, baq_eval and battery_alert_qualifier
package baq_pkg;

    // timestamp width, other field widths and the ms to us scale
    localparam int TIME_BITS    = 48;
    localparam int PCT_BITS     = 7;
    localparam int MS_BITS      = 16;
    localparam int HOLD_US_BITS = 26;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DAT_BITS = 16;
    localparam int US_PER_MS    = 1000;

    // register reset values
    localparam logic [PCT_BITS-1:0] LOW_LEVEL_RST       = PCT_BITS'(20);
    localparam logic [PCT_BITS-1:0] LOW_REARM_RST       = PCT_BITS'(25);
    localparam logic [PCT_BITS-1:0] CRIT_LEVEL_RST      = PCT_BITS'(5);
    localparam logic [PCT_BITS-1:0] CRIT_REARM_RST      = PCT_BITS'(10);
    localparam logic [HOLD_US_BITS-1:0] LOW_HOLD_US_RST  = HOLD_US_BITS'(10000 * US_PER_MS);
    localparam logic [HOLD_US_BITS-1:0] CRIT_HOLD_US_RST = HOLD_US_BITS'(5000 * US_PER_MS);
    localparam logic [HOLD_US_BITS-1:0] CHG_HOLD_US_RST  = HOLD_US_BITS'(2000 * US_PER_MS);

    // register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_LOW_LEVEL      = 3'd0,
        CFG_LOW_REARM      = 3'd1,
        CFG_CRIT_LEVEL     = 3'd2,
        CFG_CRIT_REARM     = 3'd3,
        CFG_LOW_HOLD_MS    = 3'd4,
        CFG_CRIT_HOLD_MS   = 3'd5,
        CFG_CHG_HOLD_MS    = 3'd6
    } t_cfg_idx;

    // live configuration, hold times kept in microseconds
    typedef struct packed {
        logic [PCT_BITS-1:0]     low_level;
        logic [PCT_BITS-1:0]     low_rearm;
        logic [PCT_BITS-1:0]     crit_level;
        logic [PCT_BITS-1:0]     crit_rearm;
        logic [HOLD_US_BITS-1:0] low_hold_us;
        logic [HOLD_US_BITS-1:0] crit_hold_us;
        logic [HOLD_US_BITS-1:0] chg_hold_us;
    } t_cfg;

    // one input sample
    typedef struct packed {
        logic                 sample_valid;
        logic                 is_charging;
        logic                 at_full;
        logic [PCT_BITS-1:0]  charge_percent;
        logic [TIME_BITS-1:0] time_us;
    } t_sample;

    // one result beat
    typedef struct packed {
        logic full_event;
        logic charging_event;
        logic critical_event;
        logic low_event;
    } t_events;

    // true when a started timer has run at least the hold time
    function automatic logic held(input logic [TIME_BITS-1:0]    now,
                                  input logic [TIME_BITS-1:0]    since,
                                  input logic [HOLD_US_BITS-1:0] hold_us);
        logic [TIME_BITS-1:0] diff;
        diff = now - since;
        return (now >= since) && (diff >= TIME_BITS'(hold_us));
    endfunction

endpackage

FILE: src/baq_cfg.sv
// baq_cfg: configuration registers of the battery alert qualifier
// depends on baq_pkg; hold times are scaled to microseconds at write time
module baq_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [baq_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [baq_pkg::CFG_DAT_BITS-1:0]   i_cfg_data,
    output baq_pkg::t_cfg                      o_cfg
);

    baq_pkg::t_cfg                          r_cfg;
    baq_pkg::t_cfg                          n_cfg;
    logic [baq_pkg::PCT_BITS-1:0]           pct_val;
    logic [baq_pkg::HOLD_US_BITS-1:0]       hold_us_val;

    // field slices of the write data, ms scaled to us
    assign pct_val     = i_cfg_data[baq_pkg::PCT_BITS-1:0];
    assign hold_us_val = baq_pkg::HOLD_US_BITS'(i_cfg_data[baq_pkg::MS_BITS-1:0])
                       * baq_pkg::HOLD_US_BITS'(baq_pkg::US_PER_MS);

    // write decode, unknown index ignored
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (baq_pkg::t_cfg_idx'(i_cfg_idx))
                baq_pkg::CFG_LOW_LEVEL:    n_cfg.low_level    = pct_val;
                baq_pkg::CFG_LOW_REARM:    n_cfg.low_rearm    = pct_val;
                baq_pkg::CFG_CRIT_LEVEL:   n_cfg.crit_level   = pct_val;
                baq_pkg::CFG_CRIT_REARM:   n_cfg.crit_rearm   = pct_val;
                baq_pkg::CFG_LOW_HOLD_MS:  n_cfg.low_hold_us  = hold_us_val;
                baq_pkg::CFG_CRIT_HOLD_MS: n_cfg.crit_hold_us = hold_us_val;
                baq_pkg::CFG_CHG_HOLD_MS:  n_cfg.chg_hold_us  = hold_us_val;
                default:                   n_cfg = r_cfg;
            endcase
        end
    end

    // register bank
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.low_level    <= baq_pkg::LOW_LEVEL_RST;
            r_cfg.low_rearm    <= baq_pkg::LOW_REARM_RST;
            r_cfg.crit_level   <= baq_pkg::CRIT_LEVEL_RST;
            r_cfg.crit_rearm   <= baq_pkg::CRIT_REARM_RST;
            r_cfg.low_hold_us  <= baq_pkg::LOW_HOLD_US_RST;
            r_cfg.crit_hold_us <= baq_pkg::CRIT_HOLD_US_RST;
            r_cfg.chg_hold_us  <= baq_pkg::CHG_HOLD_US_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: src/baq_eval.sv
// baq_eval: qualification state and per-sample update logic
// depends on baq_pkg; state advances only when i_step is high
module baq_eval (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  baq_pkg::t_sample  i_sample,
    input  baq_pkg::t_cfg     i_cfg,
    output baq_pkg::t_events  o_events
);

    logic                            r_seen_first, n_seen_first;
    logic                            r_prev_full,  n_prev_full;
    logic                            r_low_lat,    n_low_lat;
    logic                            r_crit_lat,   n_crit_lat;
    logic                            r_chg_lat,    n_chg_lat;
    logic [baq_pkg::TIME_BITS-1:0]   r_low_since,  n_low_since;
    logic [baq_pkg::TIME_BITS-1:0]   r_crit_since, n_crit_since;
    logic [baq_pkg::TIME_BITS-1:0]   r_chg_since,  n_chg_since;
    logic                            low_held, crit_held, chg_held;
    logic [baq_pkg::PCT_BITS-1:0]    pct;
    logic [baq_pkg::TIME_BITS-1:0]   now;

    assign pct = i_sample.charge_percent;
    assign now = i_sample.time_us;

    // hold checks against the stored start times
    assign low_held  = baq_pkg::held(now, r_low_since,  i_cfg.low_hold_us);
    assign crit_held = baq_pkg::held(now, r_crit_since, i_cfg.crit_hold_us);
    assign chg_held  = baq_pkg::held(now, r_chg_since,  i_cfg.chg_hold_us);

    // next state and events for one sample
    always_comb begin
        n_seen_first = r_seen_first;
        n_prev_full  = r_prev_full;
        n_low_lat    = r_low_lat;
        n_crit_lat   = r_crit_lat;
        n_chg_lat    = r_chg_lat;
        n_low_since  = r_low_since;
        n_crit_since = r_crit_since;
        n_chg_since  = r_chg_since;
        o_events     = '0;

        if (!i_sample.sample_valid) begin
            // bad reading drops all pending timers
            n_low_since  = '0;
            n_crit_since = '0;
            n_chg_since  = '0;
        end else begin
            // full edge, first sample only records the flag
            if (!r_seen_first) begin
                n_seen_first = 1'b1;
                n_prev_full  = i_sample.at_full;
            end else if (!r_prev_full && i_sample.at_full) begin
                o_events.full_event = 1'b1;
                n_prev_full         = 1'b1;
            end else if (!i_sample.at_full) begin
                n_prev_full = 1'b0;
            end

            if (i_sample.is_charging) begin
                // charging rearms alerts and runs the charge timer
                n_low_lat    = 1'b0;
                n_crit_lat   = 1'b0;
                n_low_since  = '0;
                n_crit_since = '0;
                if (!r_chg_lat) begin
                    if (r_chg_since == '0) begin
                        n_chg_since = now;
                    end else if (chg_held) begin
                        o_events.charging_event = 1'b1;
                        n_chg_lat               = 1'b1;
                    end
                end
            end else begin
                n_chg_since = '0;
                n_chg_lat   = 1'b0;
                if (pct > i_cfg.low_rearm) begin
                    n_low_lat = 1'b0;
                end
                if (pct > i_cfg.crit_rearm) begin
                    n_crit_lat = 1'b0;
                end

                // critical qualification, also latches low
                if (!n_crit_lat && pct <= i_cfg.crit_level) begin
                    if (r_crit_since == '0) begin
                        n_crit_since = now;
                    end else if (crit_held) begin
                        o_events.critical_event = 1'b1;
                        n_crit_lat              = 1'b1;
                        n_low_lat               = 1'b1;
                    end
                end else if (pct > i_cfg.crit_level) begin
                    n_crit_since = '0;
                end

                // low qualification sees the latch as left by critical
                if (!n_low_lat && pct < i_cfg.low_level) begin
                    if (r_low_since == '0) begin
                        n_low_since = now;
                    end else if (low_held) begin
                        o_events.low_event = 1'b1;
                        n_low_lat          = 1'b1;
                    end
                end else if (pct >= i_cfg.low_level) begin
                    n_low_since = '0;
                end
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_first <= 1'b0;
            r_prev_full  <= 1'b0;
            r_low_lat    <= 1'b0;
            r_crit_lat   <= 1'b0;
            r_chg_lat    <= 1'b0;
            r_low_since  <= '0;
            r_crit_since <= '0;
            r_chg_since  <= '0;
        end else if (i_step) begin
            r_seen_first <= n_seen_first;
            r_prev_full  <= n_prev_full;
            r_low_lat    <= n_low_lat;
            r_crit_lat   <= n_crit_lat;
            r_chg_lat    <= n_chg_lat;
            r_low_since  <= n_low_since;
            r_crit_since <= n_crit_since;
            r_chg_since  <= n_chg_since;
        end
    end

endmodule

FILE: src/battery_alert_qualifier.sv
// Battery alert qualifier: each accepted sample beat yields exactly one result beat carrying
// four one-shot event flags (full, charging started, critical, low). A sample is captured in
// an input register, evaluated against the qualification state by compare and 48-bit
// subtract logic, and written to an output register, so one beat is accepted per cycle
// while the output is not stalled, and its result beat is presented from the output
// register; input ready drops only when both registers hold beats and the output is stalled.
// Hold times are written in milliseconds and scaled to microseconds when the register is
// written. Configuration writes take effect on the next edge and belong only to idle periods.
// depends on baq_pkg, baq_cfg, baq_eval
module battery_alert_qualifier (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // sample channel
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_sample_valid,
    input  logic                               i_is_charging,
    input  logic                               i_at_full,
    input  logic [baq_pkg::PCT_BITS-1:0]       i_charge_percent,
    input  logic [baq_pkg::TIME_BITS-1:0]      i_time_us,
    // result channel
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic                               o_full_event,
    output logic                               o_charging_event,
    output logic                               o_critical_event,
    output logic                               o_low_event,
    // configuration write port
    input  logic                               i_cfg_we,
    input  logic [baq_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [baq_pkg::CFG_DAT_BITS-1:0]   i_cfg_data
);

    logic              r_in_vld;
    baq_pkg::t_sample  r_in;
    logic              r_out_vld;
    baq_pkg::t_events  r_out;
    baq_pkg::t_cfg     cfg;
    baq_pkg::t_events  events;
    logic              adv;
    logic              take;

    baq_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    baq_eval u_eval (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (adv),
        .i_sample (r_in),
        .i_cfg    (cfg),
        .o_events (events)
    );

    // pipeline handshake
    assign adv        = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || adv;
    assign take       = i_in_valid && o_in_ready;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld <= take || (r_in_vld && !adv);
            if (adv) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_in.sample_valid   <= i_sample_valid;
            r_in.is_charging    <= i_is_charging;
            r_in.at_full        <= i_at_full;
            r_in.charge_percent <= i_charge_percent;
            r_in.time_us        <= i_time_us;
        end
        if (adv) begin
            r_out <= events;
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_full_event     = r_out.full_event;
    assign o_charging_event = r_out.charging_event;
    assign o_critical_event = r_out.critical_event;
    assign o_low_event      = r_out.low_event;

    // invalid sample gives an all-clear result
    a_invalid_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && !r_in.sample_valid) |=> (o_out_valid && !o_full_event && !o_charging_event
            && !o_critical_event && !o_low_event))
        else $error("event raised by an invalid sample");

    // charging and discharge alerts are exclusive within one result
    a_chg_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_charging_event && (o_critical_event || o_low_event)))
        else $error("charging event together with a discharge alert");

    // input stalls only when both stages are full and output is blocked
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_vld && r_out_vld && !i_out_ready))
        else $error("input stalled without a full pipeline");

endmodule
